// ===== src/scpc_pkg.sv =====
package scpc_pkg;

  // fixed point
  localparam int FRAC_BITS = 16;
  localparam int COORD_BITS = 12;
  localparam int FX_W = 24;  // width of Cb, Cr and Y at 16 fraction bits

  // color conversion coefficients, c * 2^16 rounded
  localparam logic [15:0] CB_R = 16'd11056;  // 0.1687
  localparam logic [15:0] CB_G = 16'd21712;  // 0.3313
  localparam logic [15:0] CR_G = 16'd27440;  // 0.4187
  localparam logic [15:0] CR_B = 16'd5328;   // 0.0813
  localparam logic [15:0] Y_R = 16'd19595;   // 0.299
  localparam logic [15:0] Y_G = 16'd38470;   // 0.587
  localparam logic [15:0] Y_B = 16'd7471;    // 0.114

  // range model bounds (integer part)
  localparam logic [7:0] CR_LO = 8'd133;
  localparam logic [7:0] CR_HI = 8'd173;
  localparam logic [7:0] CB_LO = 8'd77;
  localparam logic [7:0] CB_HI = 8'd127;

  // ellipse constants
  localparam logic [7:0] CB_CENTER = 8'd109;
  localparam logic [7:0] CR_CENTER = 8'd152;
  localparam logic [9:0] ROT_A = 10'd819;
  localparam logic [9:0] ROT_B = 10'd614;
  localparam logic [6:0] X_OFF = 7'd51;
  localparam logic [6:0] Y_OFF = 7'd77;
  localparam logic [6:0] X_SCALE = 7'd41;
  localparam logic [6:0] Y_SCALE = 7'd73;

  // register indexes
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_LEFT = 3'd1;
  localparam logic [2:0] REG_TOP = 3'd2;
  localparam logic [2:0] REG_WIDTH = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;
  localparam logic [2:0] REG_SPLIT = 3'd5;
  localparam logic [2:0] REG_DARK = 3'd6;
  localparam logic [2:0] REG_BRIGHT = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] rect_left;
    logic [11:0] rect_top;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic [7:0]  luma_split;
    logic [19:0] dark_limit;
    logic [19:0] bright_limit;
  } cfg_t;

endpackage

// ===== src/skin_color_pixel_classifier.sv =====
// Skin color classifier, one pixel per clock. A pixel is taken on any cycle
// with start high (busy is always low) and its updated mask bit appears on
// face_out with done high once it has passed the six registered stages of the
// datapath (color conversion, range test and rotation, offset and scale,
// divide, squares, limit test). Pixels outside the programmed rectangle pass
// their mask bit through unchanged. Register writes are always ready and take
// effect on the next pixel; change them only with the pipeline empty.
module skin_color_pixel_classifier import scpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // pixel channel
  input  logic        start,
  output logic        busy,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic        face_in,
  // result channel
  output logic        done,
  output logic        face_out,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  cfg_t cfg;
  logic accept;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= 2'd1;
      cfg.rect_left <= 12'd0;
      cfg.rect_top <= 12'd0;
      cfg.rect_width <= 13'd4096;
      cfg.rect_height <= 13'd4096;
      cfg.luma_split <= 8'd100;
      cfg.dark_limit <= 20'd700;
      cfg.bright_limit <= 20'd850;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:   cfg.mode <= cfg_data[1:0];
        REG_LEFT:   cfg.rect_left <= cfg_data[11:0];
        REG_TOP:    cfg.rect_top <= cfg_data[11:0];
        REG_WIDTH:  cfg.rect_width <= cfg_data[12:0];
        REG_HEIGHT: cfg.rect_height <= cfg_data[12:0];
        REG_SPLIT:  cfg.luma_split <= cfg_data[7:0];
        REG_DARK:   cfg.dark_limit <= cfg_data;
        REG_BRIGHT: cfg.bright_limit <= cfg_data;
        default:    ;
      endcase
    end
  end

  scpc_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (accept),
    .col       (col),
    .row       (row),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .face_in   (face_in),
    .out_valid (done),
    .out_face  (face_out)
  );

endmodule

// ===== src/scpc_pipe.sv =====
module scpc_pipe import scpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic        face_in,
  output logic        out_valid,
  output logic        out_face
);

  // ---------------- stage 1: window test, Cb, Cr, Y ----------------
  logic            s1_vld;
  logic            s1_inside;
  logic            s1_face;
  logic [FX_W-1:0] s1_cb;
  logic [FX_W-1:0] s1_cr;
  logic [FX_W-1:0] s1_luma;

  logic [13:0] col_end;
  logic [13:0] row_end;
  logic        inside_c;
  logic [25:0] cb_c;
  logic [25:0] cr_c;
  logic [25:0] luma_c;

  assign col_end = 14'(cfg.rect_left) + 14'(cfg.rect_width);
  assign row_end = 14'(cfg.rect_top) + 14'(cfg.rect_height);
  assign inside_c = (col >= cfg.rect_left) && (14'(col) < col_end) &&
                    (row >= cfg.rect_top) && (14'(row) < row_end);

  // B/2 + 128 - a*R - b*G; result is always positive and below 2^24
  assign cb_c = 26'({blue, 15'd0}) + 26'(32'd128 << FRAC_BITS)
              - 26'(CB_R * 24'(red)) - 26'(CB_G * 24'(green));
  assign cr_c = 26'({red, 15'd0}) + 26'(32'd128 << FRAC_BITS)
              - 26'(CR_G * 24'(green)) - 26'(CR_B * 24'(blue));
  assign luma_c = 26'(Y_R * 24'(red)) + 26'(Y_G * 24'(green)) + 26'(Y_B * 24'(blue));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_valid;
    end
    s1_inside <= inside_c;
    s1_face <= face_in;
    s1_cb <= cb_c[FX_W-1:0];
    s1_cr <= cr_c[FX_W-1:0];
    s1_luma <= luma_c[FX_W-1:0];
  end

  // ---------------- stage 2: range model, rotation, limit pick ----------------
  logic               s2_vld;
  logic               s2_inside;
  logic               s2_face;
  logic               s2_hit;
  logic               s2_eq;
  logic [19:0]        s2_limit;
  logic signed [36:0] s2_tx;
  logic signed [36:0] s2_ty;

  logic               hit_c;
  logic               face2_c;
  logic signed [25:0] u_c;
  logic signed [25:0] v_c;
  logic signed [36:0] av_c;
  logic signed [36:0] bu_c;
  logic [FX_W-1:0]    split_fx;

  // clamping cannot change the outcome of these bounds
  assign hit_c = (s1_cr >= {CR_LO, 16'd0}) && (s1_cr <= {CR_HI, 16'd0}) &&
                 (s1_cb >= {CB_LO, 16'd0}) && (s1_cb <= {CB_HI, 16'd0});
  assign face2_c = s1_face || (s1_inside && cfg.mode[0] && hit_c);

  assign u_c = $signed({2'b00, s1_cb}) - $signed({2'b00, CB_CENTER, 16'd0});
  assign v_c = $signed({2'b00, s1_cr}) - $signed({2'b00, CR_CENTER, 16'd0});
  assign av_c = 37'(v_c) * $signed({27'd0, ROT_A});
  assign bu_c = 37'(u_c) * $signed({27'd0, ROT_B});
  assign split_fx = {cfg.luma_split, 16'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_inside <= s1_inside;
    s2_face <= face2_c;
    s2_hit <= s1_inside && cfg.mode[0] && hit_c;
    s2_eq <= (s1_luma == split_fx);
    s2_limit <= (s1_luma < split_fx) ? cfg.dark_limit : cfg.bright_limit;
    s2_tx <= av_c - bu_c;
    s2_ty <= av_c + bu_c;
  end

  // ---------------- stage 3: /32, offset, scale ----------------
  logic               s3_vld;
  logic               s3_inside;
  logic               s3_face;
  logic               s3_hit;
  logic               s3_eq;
  logic [19:0]        s3_limit;
  logic signed [40:0] s3_px;
  logic signed [40:0] s3_py;

  logic signed [36:0] tx_adj;
  logic signed [36:0] ty_adj;
  logic signed [32:0] x1_c;
  logic signed [32:0] y1_c;

  // divide toward zero: bias negatives before the shift
  assign tx_adj = s2_tx + (s2_tx[36] ? 37'sd31 : 37'sd0);
  assign ty_adj = s2_ty + (s2_ty[36] ? 37'sd31 : 37'sd0);
  assign x1_c = 33'(tx_adj >>> 5) + $signed({10'd0, X_OFF, 16'd0});
  assign y1_c = 33'(ty_adj >>> 5) + $signed({10'd0, Y_OFF, 16'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_inside <= s2_inside;
    s3_face <= s2_face;
    s3_hit <= s2_hit;
    s3_eq <= s2_eq;
    s3_limit <= s2_limit;
    s3_px <= 41'(x1_c) * $signed({34'd0, X_SCALE});
    s3_py <= 41'(y1_c) * $signed({34'd0, Y_SCALE});
  end

  // ---------------- stage 4: /1024 and magnitude ----------------
  logic        s4_vld;
  logic        s4_inside;
  logic        s4_face;
  logic        s4_hit;
  logic        s4_eq;
  logic [19:0] s4_limit;
  logic [29:0] s4_ax;
  logic [29:0] s4_ay;

  logic signed [40:0] px_adj;
  logic signed [40:0] py_adj;
  logic signed [30:0] xq;
  logic signed [30:0] yq;
  logic signed [30:0] xabs;
  logic signed [30:0] yabs;

  assign px_adj = s3_px + (s3_px[40] ? 41'sd1023 : 41'sd0);
  assign py_adj = s3_py + (s3_py[40] ? 41'sd1023 : 41'sd0);
  assign xq = 31'(px_adj >>> 10);
  assign yq = 31'(py_adj >>> 10);
  assign xabs = xq[30] ? -xq : xq;
  assign yabs = yq[30] ? -yq : yq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_inside <= s3_inside;
    s4_face <= s3_face;
    s4_hit <= s3_hit;
    s4_eq <= s3_eq;
    s4_limit <= s3_limit;
    s4_ax <= xabs[29:0];
    s4_ay <= yabs[29:0];
  end

  // ---------------- stage 5: squares ----------------
  logic        s5_vld;
  logic        s5_inside;
  logic        s5_face;
  logic        s5_hit;
  logic        s5_eq;
  logic [19:0] s5_limit;
  logic [43:0] s5_sqx;
  logic [43:0] s5_sqy;

  logic [59:0] sqx_full;
  logic [59:0] sqy_full;

  assign sqx_full = 60'(s4_ax) * 60'(s4_ax);
  assign sqy_full = 60'(s4_ay) * 60'(s4_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_inside <= s4_inside;
    s5_face <= s4_face;
    s5_hit <= s4_hit;
    s5_eq <= s4_eq;
    s5_limit <= s4_limit;
    s5_sqx <= sqx_full[59:FRAC_BITS];
    s5_sqy <= sqy_full[59:FRAC_BITS];
  end

  // ---------------- stage 6: limit test, result ----------------
  logic        s6_vld;
  logic        s6_face;
  logic        s6_in_face;
  logic        s6_hit;

  logic [44:0] value_c;
  logic        pass_c;
  logic        face6_c;

  assign value_c = 45'(s5_sqx) + 45'(s5_sqy);
  assign pass_c = !s5_eq && (value_c < 45'({s5_limit, 16'd0}));
  assign face6_c = (s5_inside && cfg.mode[1] && s5_face) ? pass_c : s5_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
    s6_face <= face6_c;
    s6_in_face <= s5_face;
    s6_hit <= s5_hit;
  end

  assign out_valid = s6_vld;
  assign out_face = s6_face;

`ifndef NO_ASSERTIONS
  // every accepted pixel comes out as a result
  a_latency: assert property (@(posedge clk) disable iff (rst) in_valid |-> ##6 out_valid)
    else $error("pixel lost in pipeline");

  // no result without a matching accepted pixel
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, 6))
    else $error("result without pixel");

  // the ellipse can only clear, never set, the mask bit
  a_only_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_face |-> s6_in_face || s6_hit)
    else $error("ellipse set a mask bit");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scpc_pkg::*;

  localparam int LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int TAIL = 12;

  // fixed-point constants, 16 fraction bits
  localparam longint ONE = 65536;
  localparam longint K_CB_R = (1687 * ONE + 5000) / 10000;
  localparam longint K_CB_G = (3313 * ONE + 5000) / 10000;
  localparam longint K_CR_G = (4187 * ONE + 5000) / 10000;
  localparam longint K_CR_B = (813 * ONE + 5000) / 10000;
  localparam longint K_Y_R = (299 * ONE + 500) / 1000;
  localparam longint K_Y_G = (587 * ONE + 500) / 1000;
  localparam longint K_Y_B = (114 * ONE + 500) / 1000;

  localparam int REG_BITS [8] = '{2, 12, 12, 13, 13, 8, 20, 20};

  // how a pixel row of the plan is checked
  typedef enum logic [1:0] {PREDICT, WANT_0, WANT_1} pin_e;
  typedef enum logic {DO_PIXEL, DO_WRITE} step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    logic [2:0]  idx;
    logic [19:0] data;
    logic [11:0] px_col;
    logic [11:0] px_row;
    logic [7:0]  px_blue;
    logic [7:0]  px_green;
    logic [7:0]  px_red;
    logic        px_face;
    pin_e        pin;
  } step_t;

  localparam int PLAN_LEN = 39;

  // directed plan: corners, clamps, luma at the split, empty and edge rectangles
  localparam step_t PLAN [PLAN_LEN] = '{
    '{DO_PIXEL, 3'd0, 20'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, WANT_0},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b1, WANT_1},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd2048, 12'd1024, 8'd120, 8'd150, 8'd200, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd4095, 12'd0, 8'd0, 8'd0, 8'd255, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd0, 12'd4095, 8'd255, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd1365, 12'd2730, 8'd128, 8'd128, 8'd128, 1'b0, WANT_0},
    '{DO_WRITE, REG_MODE, 20'd3, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd10, 12'd10, 8'd100, 8'd100, 8'd100, 1'b1, WANT_0},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd10, 12'd10, 8'd99, 8'd99, 8'd99, 1'b1, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd10, 12'd10, 8'd101, 8'd101, 8'd101, 1'b1, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd10, 12'd10, 8'd120, 8'd150, 8'd200, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd10, 12'd10, 8'd0, 8'd0, 8'd0, 1'b0, WANT_0},
    '{DO_WRITE, REG_SPLIT, 20'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_DARK, 20'hFFFFF, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_BRIGHT, 20'hFFFFF, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd20, 12'd20, 8'd120, 8'd150, 8'd200, 1'b1, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd20, 12'd20, 8'd0, 8'd0, 8'd0, 1'b1, WANT_0},
    '{DO_WRITE, REG_LEFT, 20'd100, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_TOP, 20'd200, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_WIDTH, 20'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd100, 12'd200, 8'd50, 8'd50, 8'd50, 1'b1, WANT_1},
    '{DO_WRITE, REG_WIDTH, 20'd10, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_HEIGHT, 20'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd100, 12'd200, 8'd120, 8'd150, 8'd200, 1'b0, WANT_0},
    '{DO_WRITE, REG_HEIGHT, 20'd5, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd99, 12'd200, 8'd0, 8'd0, 8'd0, 1'b1, WANT_1},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd100, 12'd200, 8'd120, 8'd150, 8'd200, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd109, 12'd204, 8'd120, 8'd150, 8'd200, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd110, 12'd204, 8'd50, 8'd50, 8'd50, 1'b1, WANT_1},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd100, 12'd205, 8'd120, 8'd150, 8'd200, 1'b0, WANT_0},
    '{DO_WRITE, REG_MODE, 20'd1, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_LEFT, 20'd4095, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_TOP, 20'd4095, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_WIDTH, 20'd8191, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_WRITE, REG_HEIGHT, 20'd8191, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd4095, 12'd4095, 8'd120, 8'd150, 8'd200, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd4094, 12'd4095, 8'd120, 8'd150, 8'd200, 1'b0, WANT_0},
    '{DO_WRITE, REG_MODE, 20'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICT},
    '{DO_PIXEL, 3'd0, 20'd0, 12'd4095, 12'd4095, 8'd120, 8'd150, 8'd200, 1'b0, WANT_0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [11:0] col;
  logic [11:0] row;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic        face_in;
  logic        done;
  logic        face_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  // register copy as the block should see it
  cfg_t cfg;

  logic mask_q [$];
  logic want_mask;
  pin_e pin_now;
  int   mismatches;
  int   cycles;

  skin_color_pixel_classifier dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .col(col),
    .row(row),
    .blue(blue),
    .green(green),
    .red(red),
    .face_in(face_in),
    .done(done),
    .face_out(face_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // updated mask bit for one pixel under the current registers
  function automatic logic skin_mask(input logic [11:0] c, input logic [11:0] rw,
                                     input logic [7:0] b8, input logic [7:0] g8,
                                     input logic [7:0] r8, input logic fin);
    longint b, g, r, cb, cr, cbc, crc, luma, u, v, x1, y1, val;
    longint cl, ct, split, dark, bright;
    logic m;
    b = longint'(b8);
    g = longint'(g8);
    r = longint'(r8);
    cl = longint'(c);
    ct = longint'(rw);
    m = fin;
    // full-width bounds, no wrap past the coordinate range
    if (cl >= longint'(cfg.rect_left) &&
        cl < longint'(cfg.rect_left) + longint'(cfg.rect_width) &&
        ct >= longint'(cfg.rect_top) &&
        ct < longint'(cfg.rect_top) + longint'(cfg.rect_height)) begin
      cb = b * ONE / 2 + 128 * ONE - K_CB_R * r - K_CB_G * g;
      cr = r * ONE / 2 + 128 * ONE - K_CR_G * g - K_CR_B * b;
      // range model on clamped chroma
      if (cfg.mode[0]) begin
        cbc = cb < 0 ? 0 : (cb > 255 * ONE ? 255 * ONE : cb);
        crc = cr < 0 ? 0 : (cr > 255 * ONE ? 255 * ONE : cr);
        if (crc >= 133 * ONE && crc <= 173 * ONE && cbc >= 77 * ONE && cbc <= 127 * ONE)
          m = 1'b1;
      end
      // ellipse on unclamped chroma, divisions truncate toward zero
      if (cfg.mode[1] && m) begin
        luma = K_Y_R * r + K_Y_G * g + K_Y_B * b;
        u = cb - 109 * ONE;
        v = cr - 152 * ONE;
        x1 = (819 * v - 614 * u) / 32 + 51 * ONE;
        y1 = (819 * v + 614 * u) / 32 + 77 * ONE;
        x1 = x1 * 41 / 1024;
        y1 = y1 * 73 / 1024;
        val = ((x1 * x1) >>> 16) + ((y1 * y1) >>> 16);
        split = longint'(cfg.luma_split);
        dark = longint'(cfg.dark_limit);
        bright = longint'(cfg.bright_limit);
        if (luma < split * ONE)
          m = val < dark * ONE;
        else if (luma > split * ONE)
          m = val < bright * ONE;
        else
          m = 1'b0;
      end
    end
    return m;
  endfunction

  // coordinate biased toward the rectangle edges
  function automatic logic [11:0] near_edge(input int base, input int size);
    int pick;
    pick = base;
    case ($urandom_range(0, 5))
      0, 1: pick = $urandom_range(0, 4095);
      2: pick = base;
      3: pick = base - 1;
      4: pick = base + size - 1;
      default: if (size > 0) pick = base + $urandom_range(0, size - 1);
    endcase
    return pick[11:0];
  endfunction

  task automatic report(input string what, input logic got, input logic want);
    $display("ERROR at %0t: %s (face_out %b, expected %b)", $time, what, got, want);
    mismatches++;
  endtask

  // one pixel word; holds start until taken
  task automatic send(input logic [11:0] c, input logic [11:0] rw, input logic [7:0] b8,
                      input logic [7:0] g8, input logic [7:0] r8, input logic f,
                      input pin_e pin);
    @(negedge clk);
    start <= 1'b1;
    col <= c;
    row <= rw;
    blue <= b8;
    green <= g8;
    red <= r8;
    face_in <= f;
    pin_now = pin;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (mask_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [19:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE: cfg.mode = data[1:0];
      REG_LEFT: cfg.rect_left = data[11:0];
      REG_TOP: cfg.rect_top = data[11:0];
      REG_WIDTH: cfg.rect_width = data[12:0];
      REG_HEIGHT: cfg.rect_height = data[12:0];
      REG_SPLIT: cfg.luma_split = data[7:0];
      REG_DARK: cfg.dark_limit = data;
      REG_BRIGHT: cfg.bright_limit = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // accepted pixels queue a prediction, strobed results are checked in order
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        if (pin_now == PREDICT)
          mask_q.push_back(skin_mask(col, row, blue, green, red, face_in));
        else
          mask_q.push_back(pin_now == WANT_1);
      end
      if (done) begin
        if (mask_q.size() == 0) begin
          report("result word with nothing pending", face_out, 1'bx);
        end else begin
          want_mask = mask_q.pop_front();
          if (face_out !== want_mask)
            report("face_out mismatch", face_out, want_mask);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [19:0] vals [8];
    logic [7:0]  b8, g8, r8;
    int          lvl;
    bit          quiet;

    rst = 1'b1;
    start = 1'b0;
    col = '0;
    row = '0;
    blue = '0;
    green = '0;
    red = '0;
    face_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin_now = PREDICT;
    mismatches = 0;
    cycles = 0;
    cfg = '{mode: 2'd1, rect_left: 12'd0, rect_top: 12'd0, rect_width: 13'd4096,
            rect_height: 13'd4096, luma_split: 8'd100, dark_limit: 20'd700,
            bright_limit: 20'd850};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed plan
    for (int k = 0; k < PLAN_LEN; k++) begin
      if (PLAN[k].kind == DO_WRITE) begin
        drain();
        set_reg(PLAN[k].idx, PLAN[k].data);
      end else begin
        // each cycle idles with a 28 percent chance
        while ($urandom_range(0, 99) < 28) idle_gap(1);
        send(PLAN[k].px_col, PLAN[k].px_row, PLAN[k].px_blue, PLAN[k].px_green,
             PLAN[k].px_red, PLAN[k].px_face, PLAN[k].pin);
      end
    end

    // random phases, each with its own register set
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: vals = '{20'd3, 20'd0, 20'd0, 20'd4096, 20'd4096, 20'd100, 20'd700, 20'd850};
        1: vals = '{default: 20'd0};
        2: vals = '{default: 20'hFFFFF};
        default: begin
          vals[0] = 20'($urandom_range(0, 3));
          vals[1] = 20'($urandom_range(0, 4095));
          vals[2] = 20'($urandom_range(0, 4095));
          for (int k = 3; k <= 4; k++) begin
            case ($urandom_range(0, 2))
              0: vals[k] = 20'($urandom_range(0, 64));
              1: vals[k] = 20'($urandom_range(0, 8191));
              default: vals[k] = 20'd4096;
            endcase
          end
          vals[5] = 20'($urandom_range(0, 255));
          for (int k = 6; k <= 7; k++) begin
            case ($urandom_range(0, 3))
              0: vals[k] = 20'd0;
              1: vals[k] = 20'hFFFFF;
              2: vals[k] = 20'($urandom_range(0, 3000));
              default: vals[k] = 20'($urandom_range(0, 20'hFFFFF));
            endcase
          end
          // junk above the register width must be ignored
          for (int k = 0; k < 8; k++)
            if ($urandom_range(0, 1))
              vals[k] |= 20'((20'hFFFFF << REG_BITS[k]) & $urandom);
        end
      endcase
      for (int k = 0; k < 8; k++) set_reg(k[2:0], vals[k]);

      quiet = (ph == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (!quiet)
          while ($urandom_range(0, 99) < 28) idle_gap(1);
        if (ph == 4 && i == PHASE_ITEMS / 2) drain();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            b8 = 8'($urandom);
            g8 = 8'($urandom);
            r8 = 8'($urandom);
          end
          4: begin
            // gray at the split level lands luma exactly on it
            b8 = cfg.luma_split;
            g8 = cfg.luma_split;
            r8 = cfg.luma_split;
          end
          default: begin
            lvl = $urandom_range(90, 255);
            r8 = 8'(lvl);
            lvl = lvl * $urandom_range(45, 85) / 100;
            g8 = 8'(lvl);
            lvl = lvl * $urandom_range(55, 110) / 100;
            b8 = 8'(lvl);
          end
        endcase
        send(near_edge(int'(cfg.rect_left), int'(cfg.rect_width)),
             near_edge(int'(cfg.rect_top), int'(cfg.rect_height)),
             b8, g8, r8, 1'($urandom_range(0, 1)), PREDICT);
      end
    end

    drain();
    repeat (TAIL) @(posedge clk);
    if (mask_q.size() != 0) report("expected results left over", 1'bx, mask_q[0]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
